// ===== sv/point_axis_rotator_macros.svh =====
// ============================================================================
// Assertion macros for the point axis rotator
// Shorthand for the clocked concurrent checks used by the rotator's checker.
// The macros expect signals named i_clk and i_rst_n in the using scope.
// ============================================================================
`ifndef POINT_AXIS_ROTATOR_MACROS_SVH
`define POINT_AXIS_ROTATOR_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define PAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked during reset.
`define PAR_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/par_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Point axis rotator package
// Shared widths, angle constants, the CORDIC arctangent table and the
// pipeline tag type.
// ============================================================================
package par_pkg;

    localparam int COORD_BITS_DEF  = 32;
    localparam int TRIG_STAGES_DEF = 16;

    localparam int KIND_W       = 2;
    localparam int ANGLE_W      = 16;
    localparam int TRIG_W       = 32;
    localparam int TRIG_FRAC    = 29;
    localparam int Z_W          = 25;
    localparam int Z_SHIFT      = 10;
    localparam int ATAN_ENTRIES = 24;

    // Start vector length: the CORDIC gain 0.6072529350 in Q2.29.
    localparam logic signed [TRIG_W-1:0] TRIG_GAIN = 32'sd326016437;

    // Angles in 1/64 degree: 360, 180 and 90 degrees.
    localparam logic signed [ANGLE_W:0] ANGLE_FULL    = 17'sd23040;
    localparam logic signed [ANGLE_W:0] ANGLE_HALF    = 17'sd11520;
    localparam logic signed [ANGLE_W:0] ANGLE_QUARTER = 17'sd5760;

    typedef enum logic [KIND_W-1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    typedef struct packed {
        logic  valid;
        t_axis kind;
    } t_tag;

    // atan(2^-idx) in degrees, scaled by 65536 and rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            0:       val = Z_W'(2949120);
            1:       val = Z_W'(1740967);
            2:       val = Z_W'(919879);
            3:       val = Z_W'(466945);
            4:       val = Z_W'(234379);
            5:       val = Z_W'(117304);
            6:       val = Z_W'(58666);
            7:       val = Z_W'(29335);
            8:       val = Z_W'(14668);
            9:       val = Z_W'(7334);
            10:      val = Z_W'(3667);
            11:      val = Z_W'(1833);
            12:      val = Z_W'(917);
            13:      val = Z_W'(458);
            14:      val = Z_W'(229);
            15:      val = Z_W'(115);
            16:      val = Z_W'(57);
            17:      val = Z_W'(29);
            18:      val = Z_W'(14);
            19:      val = Z_W'(7);
            20:      val = Z_W'(4);
            21:      val = Z_W'(2);
            22:      val = Z_W'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== sv/par_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Point axis rotator channels
// Valid/ready channels for the input point transaction and the rotated
// result transaction.
// ============================================================================
interface par_in_if #(
    parameter int COORD_BITS = par_pkg::COORD_BITS_DEF
);
    import par_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [KIND_W-1:0]            kind;
    logic signed [ANGLE_W-1:0]    angle_deg;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;

    modport source (output valid, kind, angle_deg, px, py, pz, input ready);
    modport sink   (input valid, kind, angle_deg, px, py, pz, output ready);
endinterface

interface par_out_if #(
    parameter int COORD_BITS = par_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] rx;
    logic signed [COORD_BITS-1:0] ry;
    logic signed [COORD_BITS-1:0] rz;
    logic                         clipped;

    modport source (output valid, rx, ry, rz, clipped, input ready);
    modport sink   (input valid, rx, ry, rz, clipped, output ready);
endinterface

// ===== sv/par_reduce.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Angle reduction stage
// Wraps the angle into one turn, folds it into [-90, 90] degrees and scales
// it to 2^-16 degree for the CORDIC.
// ============================================================================
module par_reduce (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [par_pkg::ANGLE_W-1:0] i_angle,
    output logic signed [par_pkg::Z_W-1:0]     o_z,
    output logic                              o_neg
);
    import par_pkg::*;

    logic signed [ANGLE_W:0] w_wide;
    logic signed [ANGLE_W:0] w_wrap;
    logic signed [ANGLE_W:0] w_fold;
    logic signed [Z_W-1:0]   n_z;
    logic                    n_neg;
    logic signed [Z_W-1:0]   r_z;
    logic                    r_neg;

    always_comb begin
        w_wide = (ANGLE_W+1)'(i_angle);
        if (w_wide >= ANGLE_HALF) begin
            w_wrap = w_wide - ANGLE_FULL;
        end else if (w_wide < -ANGLE_HALF) begin
            w_wrap = w_wide + ANGLE_FULL;
        end else begin
            w_wrap = w_wide;
        end
        // Beyond a quarter turn, rotate by half a turn and negate sin and cos.
        if (w_wrap > ANGLE_QUARTER) begin
            w_fold = w_wrap - ANGLE_HALF;
            n_neg  = 1'b1;
        end else if (w_wrap < -ANGLE_QUARTER) begin
            w_fold = w_wrap + ANGLE_HALF;
            n_neg  = 1'b1;
        end else begin
            w_fold = w_wrap;
            n_neg  = 1'b0;
        end
        n_z = Z_W'(w_fold) <<< Z_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z   <= n_z;
            r_neg <= n_neg;
        end
    end

    assign o_z   = r_z;
    assign o_neg = r_neg;

endmodule

// ===== sv/par_cordic.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Pipelined sine/cosine CORDIC
// One rotation-mode micro-rotation per register stage, followed by a stage
// that applies the half-turn sign and also provides the negated sine.
// ============================================================================
module par_cordic #(
    parameter int TRIG_STAGES = par_pkg::TRIG_STAGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [par_pkg::Z_W-1:0]     i_z,
    input  logic                               i_neg,
    output logic signed [par_pkg::TRIG_W-1:0]  o_cos,
    output logic signed [par_pkg::TRIG_W-1:0]  o_sin,
    output logic signed [par_pkg::TRIG_W-1:0]  o_nsin
);
    import par_pkg::*;

    localparam int NSTAGE = (TRIG_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_STAGES;

    logic signed [TRIG_W-1:0] r_x   [NSTAGE];
    logic signed [TRIG_W-1:0] r_y   [NSTAGE];
    logic signed [Z_W-1:0]    r_ang [NSTAGE];
    logic                     r_neg [NSTAGE];
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [TRIG_W-1:0] r_nsin;

    for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
        logic signed [TRIG_W-1:0] w_x;
        logic signed [TRIG_W-1:0] w_y;
        logic signed [Z_W-1:0]    w_ang;
        logic                     w_neg;
        logic signed [TRIG_W-1:0] n_x;
        logic signed [TRIG_W-1:0] n_y;
        logic signed [Z_W-1:0]    n_ang;

        if (k == 0) begin : g_first
            assign w_x   = TRIG_GAIN;
            assign w_y   = '0;
            assign w_ang = i_z;
            assign w_neg = i_neg;
        end else begin : g_next
            assign w_x   = r_x[k-1];
            assign w_y   = r_y[k-1];
            assign w_ang = r_ang[k-1];
            assign w_neg = r_neg[k-1];
        end

        // Rotate toward zero residual angle; shifts are arithmetic (floor).
        always_comb begin
            if (!w_ang[Z_W-1]) begin
                n_x   = w_x - (w_y >>> k);
                n_y   = w_y + (w_x >>> k);
                n_ang = w_ang - atan_entry(k);
            end else begin
                n_x   = w_x + (w_y >>> k);
                n_y   = w_y - (w_x >>> k);
                n_ang = w_ang + atan_entry(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]   <= n_x;
                r_y[k]   <= n_y;
                r_ang[k] <= n_ang;
                r_neg[k] <= w_neg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[NSTAGE-1]) begin
                r_cos  <= -r_x[NSTAGE-1];
                r_sin  <= -r_y[NSTAGE-1];
                r_nsin <= r_y[NSTAGE-1];
            end else begin
                r_cos  <= r_x[NSTAGE-1];
                r_sin  <= r_y[NSTAGE-1];
                r_nsin <= -r_y[NSTAGE-1];
            end
        end
    end

    assign o_cos  = r_cos;
    assign o_sin  = r_sin;
    assign o_nsin = r_nsin;

endmodule

// ===== sv/par_mix.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Rotation product unit
// Computes round(a*c - b*s) in Q16.16 from Q2.29 trig values over three
// register stages, then saturates the result to the coordinate range.
// ============================================================================
module par_mix #(
    parameter int COORD_BITS = par_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [COORD_BITS-1:0]      i_a,
    input  logic signed [COORD_BITS-1:0]      i_b,
    input  logic signed [par_pkg::TRIG_W-1:0] i_c,
    input  logic signed [par_pkg::TRIG_W-1:0] i_s,
    output logic signed [COORD_BITS-1:0]      o_val,
    output logic                              o_clip
);
    import par_pkg::*;

    // Each coordinate is split into a signed upper half and an unsigned lower
    // half so that no multiplier exceeds 17 by 32 bits with the default widths.
    localparam int LO_W  = COORD_BITS / 2;
    localparam int HI_W  = COORD_BITS - LO_W;
    localparam int PH_W  = HI_W + TRIG_W;
    localparam int PL_W  = LO_W + 1 + TRIG_W;
    localparam int SUM_W = COORD_BITS + TRIG_W + 2;
    localparam int Q_W   = SUM_W - TRIG_FRAC;

    localparam logic signed [SUM_W-1:0]      ROUND   = SUM_W'(2 ** (TRIG_FRAC - 1));
    localparam logic signed [COORD_BITS-1:0] SAT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] SAT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [HI_W-1:0]  w_ah;
    logic signed [HI_W-1:0]  w_bh;
    logic signed [LO_W:0]    w_al;
    logic signed [LO_W:0]    w_bl;
    logic signed [PH_W-1:0]  r_ahc;
    logic signed [PH_W-1:0]  r_bhs;
    logic signed [PL_W-1:0]  r_alc;
    logic signed [PL_W-1:0]  r_bls;
    logic signed [PH_W:0]    r_hi;
    logic signed [PL_W:0]    r_lo;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [Q_W-1:0]   w_q;
    logic [Q_W-COORD_BITS:0] w_top;
    logic                    w_ovf;

    assign w_ah = $signed(i_a[COORD_BITS-1:LO_W]);
    assign w_bh = $signed(i_b[COORD_BITS-1:LO_W]);
    assign w_al = $signed({1'b0, i_a[LO_W-1:0]});
    assign w_bl = $signed({1'b0, i_b[LO_W-1:0]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ahc <= w_ah * i_c;
            r_bhs <= w_bh * i_s;
            r_alc <= w_al * i_c;
            r_bls <= w_bl * i_s;
            r_hi  <= (PH_W+1)'(r_ahc) - (PH_W+1)'(r_bhs);
            r_lo  <= (PL_W+1)'(r_alc) - (PL_W+1)'(r_bls);
            r_sum <= (SUM_W'(r_hi) <<< LO_W) + SUM_W'(r_lo) + ROUND;
        end
    end

    // The quotient fits when its bits from the coordinate sign upward all agree.
    assign w_q    = $signed(r_sum[SUM_W-1:TRIG_FRAC]);
    assign w_top  = w_q[Q_W-1:COORD_BITS-1];
    assign w_ovf  = !((&w_top) || !(|w_top));
    assign o_clip = w_ovf;
    assign o_val  = w_ovf ? (w_q[Q_W-1] ? SAT_MIN : SAT_MAX) : w_q[COORD_BITS-1:0];

endmodule

// ===== sv/point_axis_rotator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Point axis rotator
// Rotates a Q16.16 point right-handedly about the X, Y or Z axis.
// ============================================================================
// Usage: i_pt carries one point transaction (kind, angle_deg in 1/64 degree,
// px/py/pz in signed Q16.16); o_res returns one transaction per input with
// the rotated coordinates and a clipped flag that marks saturation. Both
// channels transfer when valid and ready are high at a rising clock edge.
// Kind 3 returns the point unchanged. Any angle pattern is wrapped modulo
// 360 degrees.
// The pipeline has one reduction stage, one CORDIC micro-rotation stage per
// TRIG_STAGES (capped at 24), a sign stage, three multiply/accumulate stages
// and the output register.
// Throughput is one transaction per cycle while the receiver does not stall;
// the CORDIC stages and the split multipliers are fully pipelined.
// A synchronous active-low reset empties the pipeline at once. When the
// receiver stalls, the whole pipeline holds in place and i_pt.ready drops
// only while the output register is full and not being taken, so nothing
// is lost or repeated.
// ============================================================================
module point_axis_rotator #(
    parameter int COORD_BITS  = par_pkg::COORD_BITS_DEF,
    parameter int TRIG_STAGES = par_pkg::TRIG_STAGES_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    par_in_if.sink    i_pt,
    par_out_if.source o_res
);
    import par_pkg::*;

    localparam int NSTAGE   = (TRIG_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_STAGES;
    // Tag and point delay line: taps where the mixers start and where the
    // output stage assembles the result.
    localparam int PT_DEPTH = NSTAGE + 5;
    localparam int MIX_TAP  = NSTAGE + 1;
    localparam int OUT_TAP  = NSTAGE + 4;

    logic                          w_adv;
    t_tag                          r_tag [PT_DEPTH];
    logic signed [COORD_BITS-1:0]  r_px  [PT_DEPTH];
    logic signed [COORD_BITS-1:0]  r_py  [PT_DEPTH];
    logic signed [COORD_BITS-1:0]  r_pz  [PT_DEPTH];

    logic signed [Z_W-1:0]         w_z;
    logic                          w_neg;
    logic signed [TRIG_W-1:0]      w_cos;
    logic signed [TRIG_W-1:0]      w_sin;
    logic signed [TRIG_W-1:0]      w_nsin;
    logic signed [COORD_BITS-1:0]  w_u;
    logic signed [COORD_BITS-1:0]  w_v;
    logic signed [COORD_BITS-1:0]  w_u_rot;
    logic signed [COORD_BITS-1:0]  w_v_rot;
    logic                          w_u_clip;
    logic                          w_v_clip;

    logic signed [COORD_BITS-1:0]  n_rx;
    logic signed [COORD_BITS-1:0]  n_ry;
    logic signed [COORD_BITS-1:0]  n_rz;
    logic                          n_clipped;
    logic signed [COORD_BITS-1:0]  r_rx;
    logic signed [COORD_BITS-1:0]  r_ry;
    logic signed [COORD_BITS-1:0]  r_rz;
    logic                          r_clipped;
    logic                          r_out_valid;

    // The pipeline moves as a whole whenever the output register can accept.
    assign w_adv      = !r_out_valid || o_res.ready;
    assign i_pt.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PT_DEPTH; i++) begin
                r_tag[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_tag[0] <= '{valid: i_pt.valid, kind: t_axis'(i_pt.kind)};
            for (int i = 1; i < PT_DEPTH; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
            r_out_valid <= r_tag[OUT_TAP].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_px[0] <= i_pt.px;
            r_py[0] <= i_pt.py;
            r_pz[0] <= i_pt.pz;
            for (int i = 1; i < PT_DEPTH; i++) begin
                r_px[i] <= r_px[i-1];
                r_py[i] <= r_py[i-1];
                r_pz[i] <= r_pz[i-1];
            end
        end
    end

    par_reduce u_reduce (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_angle (i_pt.angle_deg),
        .o_z     (w_z),
        .o_neg   (w_neg)
    );

    par_cordic #(
        .TRIG_STAGES (TRIG_STAGES)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_z    (w_z),
        .i_neg  (w_neg),
        .o_cos  (w_cos),
        .o_sin  (w_sin),
        .o_nsin (w_nsin)
    );

    // The rotated pair (u, v) is (y, z) for X, (z, x) for Y and (x, y) for Z.
    always_comb begin
        case (r_tag[MIX_TAP].kind)
            AXIS_X: begin
                w_u = r_py[MIX_TAP];
                w_v = r_pz[MIX_TAP];
            end
            AXIS_Y: begin
                w_u = r_pz[MIX_TAP];
                w_v = r_px[MIX_TAP];
            end
            default: begin
                w_u = r_px[MIX_TAP];
                w_v = r_py[MIX_TAP];
            end
        endcase
    end

    // u' = u*cos - v*sin and v' = v*cos - u*(-sin).
    par_mix #(
        .COORD_BITS (COORD_BITS)
    ) u_mix_u (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_a    (w_u),
        .i_b    (w_v),
        .i_c    (w_cos),
        .i_s    (w_sin),
        .o_val  (w_u_rot),
        .o_clip (w_u_clip)
    );

    par_mix #(
        .COORD_BITS (COORD_BITS)
    ) u_mix_v (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_a    (w_v),
        .i_b    (w_u),
        .i_c    (w_cos),
        .i_s    (w_nsin),
        .o_val  (w_v_rot),
        .o_clip (w_v_clip)
    );

    // Put the rotated pair back in place; the axis coordinate passes through.
    always_comb begin
        n_rx      = r_px[OUT_TAP];
        n_ry      = r_py[OUT_TAP];
        n_rz      = r_pz[OUT_TAP];
        n_clipped = w_u_clip || w_v_clip;
        case (r_tag[OUT_TAP].kind)
            AXIS_X: begin
                n_ry = w_u_rot;
                n_rz = w_v_rot;
            end
            AXIS_Y: begin
                n_rz = w_u_rot;
                n_rx = w_v_rot;
            end
            AXIS_Z: begin
                n_rx = w_u_rot;
                n_ry = w_v_rot;
            end
            default: begin
                n_clipped = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rx      <= n_rx;
            r_ry      <= n_ry;
            r_rz      <= n_rz;
            r_clipped <= n_clipped;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.rx      = r_rx;
    assign o_res.ry      = r_ry;
    assign o_res.rz      = r_rz;
    assign o_res.clipped = r_clipped;

endmodule

// ===== sv/par_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Point axis rotator checker
// Port-level checks on the rotator's handshake and saturated results.
// ============================================================================
`include "point_axis_rotator_macros.svh"

module par_checker #(
    parameter int COORD_BITS = par_pkg::COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [COORD_BITS-1:0] i_rx,
    input logic [COORD_BITS-1:0] i_ry,
    input logic [COORD_BITS-1:0] i_rz,
    input logic                  i_clipped
);
    import par_pkg::*;

    localparam logic [COORD_BITS-1:0] SAT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] SAT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic                  w_in_offer;
    logic [3*COORD_BITS:0] w_res;
    logic                  w_sat;

    // An input offer is only ever refused because the output is full.
    assign w_in_offer = i_in_valid;

    assign w_res = {i_rx, i_ry, i_rz, i_clipped};

    // At least one coordinate sits at a limit of the coordinate range.
    assign w_sat = (i_rx == SAT_MAX) || (i_rx == SAT_MIN) ||
                   (i_ry == SAT_MAX) || (i_ry == SAT_MIN) ||
                   (i_rz == SAT_MAX) || (i_rz == SAT_MIN);

    `PAR_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `PAR_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(w_res), "result changed while stalled")
    `PAR_ASSERT_NOW(a_clip_sat, i_out_valid && i_clipped, w_sat, "clipped set without a saturated coordinate")
    `PAR_ASSERT_NOW(a_ready_free, w_in_offer && !i_out_valid, i_in_ready, "input refused with empty output")
    `PAR_ASSERT_RESET(a_reset_empty, !i_rst_n, !i_out_valid, "result valid after reset")

endmodule

bind point_axis_rotator par_checker #(
    .COORD_BITS (COORD_BITS)
) u_par_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_rx        (o_res.rx),
    .i_ry        (o_res.ry),
    .i_rz        (o_res.rz),
    .i_clipped   (o_res.clipped)
);

// ===== test/point_axis_rotator_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Point axis rotator testbench
// Streams point transactions through the rotator and checks every rotated
// result against a bit-exact software rotation built on its own CORDIC
// sine/cosine. A directed table comes first, then random points under two
// sender/receiver idling mixes and one long receiver hold-off without idling.
// ============================================================================
module point_axis_rotator_test;
    import par_pkg::*;

    localparam int COORD_W        = COORD_BITS_DEF;
    localparam int STAGES         = TRIG_STAGES_DEF;
    localparam int PIPE_LATENCY   = STAGES + 6;
    localparam int DRAIN_CYCLES   = PIPE_LATENCY + 20;
    localparam int QUIET_LIMIT    = 2000;
    localparam int HOLD_CYCLES    = 120;
    localparam int RANDOM_PER_MIX = 320;
    localparam int SHOWN_FAULTS   = 10;

    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    // 1.0 in Q16.16.
    localparam logic signed [COORD_W-1:0] ONE   = COORD_W'(32'sh0001_0000);

    // atan(2^-k) in degrees scaled by 65536, rounded to nearest.
    localparam longint ATAN_TABLE [ATAN_ENTRIES] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        t_axis                      kind;
        logic signed [ANGLE_W-1:0]  angle;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  pz;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  rx;
        logic signed [COORD_W-1:0]  ry;
        logic signed [COORD_W-1:0]  rz;
        logic                       clipped;
    } rotated_t;

    typedef struct packed {
        point_t   pt;
        logic     typed;
        rotated_t want;
    } row_t;

    localparam rotated_t UNTYPED    = '0;
    localparam rotated_t ZERO_POINT = '0;

    // Directed rows. Only pass-through and zero points carry a typed result;
    // all others are checked against the software rotation.
    localparam row_t DIRECTED_ROWS [24] = '{
        // Zero angle, quarter turns and the wrap points of the angle range.
        '{'{AXIS_Z,    0,      ONE,   0,     0    }, 1'b0, UNTYPED},
        '{'{AXIS_X,    5760,   0,     ONE,   0    }, 1'b0, UNTYPED},
        '{'{AXIS_Y,   -5760,   ONE,   2*ONE, 3*ONE}, 1'b0, UNTYPED},
        '{'{AXIS_Z,    11520,  ONE,  -ONE,   ONE  }, 1'b0, UNTYPED},
        '{'{AXIS_Z,   -11520,  ONE,  -ONE,   ONE  }, 1'b0, UNTYPED},
        '{'{AXIS_X,    23039,  ONE,   ONE,  -ONE  }, 1'b0, UNTYPED},
        '{'{AXIS_X,   -23040,  ONE,   ONE,  -ONE  }, 1'b0, UNTYPED},
        // Just past and just short of a quarter turn: the half-turn fold.
        '{'{AXIS_Y,    5761,   3*ONE, ONE,   2*ONE}, 1'b0, UNTYPED},
        '{'{AXIS_Y,   -5761,   3*ONE, ONE,   2*ONE}, 1'b0, UNTYPED},
        '{'{AXIS_Z,    5759,  -ONE,   ONE,   ONE  }, 1'b0, UNTYPED},
        // Coordinate extremes, several of which must saturate.
        '{'{AXIS_Z,    1,      C_MAX, C_MAX, C_MAX}, 1'b0, UNTYPED},
        '{'{AXIS_Z,    2880,   C_MAX, C_MAX, 0    }, 1'b0, UNTYPED},
        '{'{AXIS_Z,   -8640,   C_MIN, C_MIN, C_MIN}, 1'b0, UNTYPED},
        '{'{AXIS_X,    11519,  C_MIN, C_MIN, C_MAX}, 1'b0, UNTYPED},
        // Angles past +-180 degrees wrap modulo a full turn; 1920 is 30 degrees.
        '{'{AXIS_Y,    32767,  C_MAX, ONE,   C_MIN}, 1'b0, UNTYPED},
        '{'{AXIS_X,   -32768,  ONE,   C_MIN, C_MAX}, 1'b0, UNTYPED},
        '{'{AXIS_Z,    17280,  ONE,   0,     0    }, 1'b0, UNTYPED},
        '{'{AXIS_X,   -17280,  0,     ONE,  -ONE  }, 1'b0, UNTYPED},
        '{'{AXIS_Y,    1920,  -1,    -1,    -1    }, 1'b0, UNTYPED},
        // The unused axis code passes the point through untouched.
        '{'{AXIS_NONE, 1234,   C_MAX, C_MIN, 32'sh1234_5678}, 1'b1,
          '{C_MAX, C_MIN, 32'sh1234_5678, 1'b0}},
        '{'{AXIS_NONE, -32768, -1,    0,     C_MIN}, 1'b1,
          '{-1, 0, C_MIN, 1'b0}},
        // The origin stays at the origin whatever the angle.
        '{'{AXIS_X,    2880,   0,     0,     0    }, 1'b1, ZERO_POINT},
        '{'{AXIS_Y,    32767,  0,     0,     0    }, 1'b1, ZERO_POINT},
        '{'{AXIS_Z,   -23040,  0,     0,     0    }, 1'b1, ZERO_POINT}
    };

    logic i_clk;
    logic i_rst_n;

    par_in_if  #(.COORD_BITS(COORD_W)) pt_bus ();
    par_out_if #(.COORD_BITS(COORD_W)) res_bus ();

    point_axis_rotator #(
        .COORD_BITS  (COORD_W),
        .TRIG_STAGES (STAGES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_bus),
        .o_res   (res_bus)
    );

    rotated_t pending_rotations [$];
    int       fault_count;
    int       result_count;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_request;
    int       quiet_cycles;

    // ------------------------------------------------------------------------
    // Software rotation
    // ------------------------------------------------------------------------

    // Cosine and sine in Q2.29 from a rotation-mode CORDIC. The angle is
    // wrapped into [-180, 180) degrees and folded into [-90, 90], with both
    // outputs negated when folded.
    function automatic void trig_pair(input logic signed [ANGLE_W-1:0] angle,
                                      output longint cos_q, output longint sin_q);
        longint a;
        longint x;
        longint y;
        longint z;
        longint nx;
        bit     flip;
        a    = angle;
        flip = 1'b0;
        while (a >= longint'(ANGLE_HALF)) a -= longint'(ANGLE_FULL);
        while (a < -longint'(ANGLE_HALF)) a += longint'(ANGLE_FULL);
        if (a > longint'(ANGLE_QUARTER)) begin
            a -= longint'(ANGLE_HALF);
            flip = 1'b1;
        end else if (a < -longint'(ANGLE_QUARTER)) begin
            a += longint'(ANGLE_HALF);
            flip = 1'b1;
        end
        x = longint'(TRIG_GAIN);
        y = 0;
        z = a * 1024;
        for (int k = 0; k < STAGES && k < ATAN_ENTRIES; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> k);
                y  = y + (x >>> k);
                z  = z - ATAN_TABLE[k];
            end else begin
                nx = x + (y >>> k);
                y  = y - (x >>> k);
                z  = z + ATAN_TABLE[k];
            end
            x = nx;
        end
        cos_q = flip ? -x : x;
        sin_q = flip ? -y : y;
    endfunction

    // floor((u*c - v*s + 2^28) / 2^29); exact in 64 bits for 32-bit points.
    function automatic longint blend(input longint u, input longint c,
                                     input longint v, input longint s);
        return (u * c - v * s + (longint'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    endfunction

    function automatic longint clamp_coord(input longint v, inout bit clip);
        longint top;
        top = (longint'(1) <<< (COORD_W - 1)) - 1;
        if (v > top) begin
            clip = 1'b1;
            return top;
        end
        if (v < -top - 1) begin
            clip = 1'b1;
            return -top - 1;
        end
        return v;
    endfunction

    function automatic rotated_t rotate_point(input point_t p);
        longint   coord [3];
        longint   moved [3];
        longint   c;
        longint   s;
        int       iu;
        int       iv;
        bit       clip;
        rotated_t res;
        coord[0] = p.px;
        coord[1] = p.py;
        coord[2] = p.pz;
        moved    = coord;
        clip     = 1'b0;
        if (p.kind != AXIS_NONE) begin
            // The rotated pair (u, v) is (y, z), (z, x) or (x, y).
            case (p.kind)
                AXIS_X: begin
                    iu = 1;
                    iv = 2;
                end
                AXIS_Y: begin
                    iu = 2;
                    iv = 0;
                end
                default: begin
                    iu = 0;
                    iv = 1;
                end
            endcase
            trig_pair(p.angle, c, s);
            moved[iu] = clamp_coord(blend(coord[iu], c, coord[iv], s), clip);
            moved[iv] = clamp_coord(blend(coord[iv], c, coord[iu], -s), clip);
        end
        res.rx      = COORD_W'(moved[0]);
        res.ry      = COORD_W'(moved[1]);
        res.rz      = COORD_W'(moved[2]);
        res.clipped = clip;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Random points
    // ------------------------------------------------------------------------

    // Coordinates lean toward small values, with a share of full-range words,
    // exact extremes and large magnitudes that are likely to saturate.
    function automatic logic signed [COORD_W-1:0] random_coord();
        logic [COORD_W-1:0] word;
        int unsigned        pick;
        pick = $urandom_range(99);
        word = COORD_W'($urandom);
        if (pick < 45)
            return COORD_W'(int'($urandom_range(0, 2097152)) - 1048576);
        if (pick < 80)
            return word;
        if (pick < 90) begin
            case ($urandom_range(3))
                0:       return C_MAX;
                1:       return C_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        word[COORD_W-2] = ~word[COORD_W-1];
        return word;
    endfunction

    function automatic point_t random_point();
        point_t      p;
        int unsigned pick;
        p.kind = ($urandom_range(99) < 90) ? t_axis'($urandom_range(2)) : AXIS_NONE;
        pick   = $urandom_range(99);
        if (pick < 70)
            p.angle = ANGLE_W'(int'($urandom_range(0, 46079)) - 23040);
        else if (pick < 85)
            p.angle = ANGLE_W'($urandom_range(0, 65535));
        else
            // Multiples of 45 degrees hit the fold and wrap boundaries.
            p.angle = ANGLE_W'((int'($urandom_range(0, 15)) - 8) * 2880);
        p.px = random_coord();
        p.py = random_coord();
        p.pz = random_coord();
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset and the input side
    // ------------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Offers one point transaction, with random idle cycles ahead of it, and
    // records the expected rotation once the rotator has taken it. Inputs
    // change on the falling edge; acceptance is sampled on the rising edge.
    task automatic push_point(input point_t p, input rotated_t want);
        @(negedge i_clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            pt_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt_bus.valid     <= 1'b1;
        pt_bus.kind      <= p.kind;
        pt_bus.angle_deg <= p.angle;
        pt_bus.px        <= p.px;
        pt_bus.py        <= p.py;
        pt_bus.pz        <= p.pz;
        do @(posedge i_clk); while (!pt_bus.ready);
        pending_rotations.push_back(want);
    endtask

    task automatic run_random(input int count);
        point_t p;
        for (int n = 0; n < count; n++) begin
            p = random_point();
            push_point(p, rotate_point(p));
        end
    endtask

    initial begin
        row_t row;
        i_rst_n          = 1'b0;
        pt_bus.valid     = 1'b0;
        pt_bus.kind      = '0;
        pt_bus.angle_deg = '0;
        pt_bus.px        = '0;
        pt_bus.py        = '0;
        pt_bus.pz        = '0;
        res_bus.ready    = 1'b0;
        fault_count      = 0;
        result_count     = 0;
        hold_request     = 1'b0;
        send_idle_pct    = 36;
        recv_idle_pct    = 75;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows run under the first idling mix.
        foreach (DIRECTED_ROWS[i]) begin
            row = DIRECTED_ROWS[i];
            push_point(row.pt, row.typed ? row.want : rotate_point(row.pt));
        end
        run_random(RANDOM_PER_MIX);

        send_idle_pct = 75;
        recv_idle_pct = 36;
        run_random(RANDOM_PER_MIX);

        // No idling, but the receiver first holds off for a long stretch while
        // points keep coming, so the pipeline fills and stalls the input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        run_random(RANDOM_PER_MIX);

        @(negedge i_clk);
        pt_bus.valid <= 1'b0;

        // The watchdog bounds this wait if results go missing.
        while (pending_rotations.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("point_axis_rotator_test: done, clean");
        end else begin
            $display("point_axis_rotator_test: done, errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // Ready toggles at random per the current mix. A hold request drops ready
    // and keeps it low until its count here runs out, then clears itself.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= SHOWN_FAULTS)
            $display("[%0t] FAULT: %s", $realtime, msg);
    endtask

    // Each result transaction is matched against the oldest expected rotation.
    always @(posedge i_clk) begin
        rotated_t want;
        rotated_t got;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got.rx      = res_bus.rx;
            got.ry      = res_bus.ry;
            got.rz      = res_bus.rz;
            got.clipped = res_bus.clipped;
            result_count++;
            if (pending_rotations.size() == 0) begin
                note_fault($sformatf("result %0d arrived with none expected", result_count));
            end else begin
                want = pending_rotations.pop_front();
                if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz ||
                    got.clipped !== want.clipped) begin
                    note_fault($sformatf(
                        "result %0d: expected %h %h %h clip %b, got %h %h %h clip %b",
                        result_count, want.rx, want.ry, want.rz, want.clipped,
                        got.rx, got.ry, got.rz, got.clipped));
                end
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((pt_bus.valid && pt_bus.ready) || (res_bus.valid && res_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] watchdog: no transaction for %0d cycles, %0d results pending",
                 $realtime, QUIET_LIMIT, pending_rotations.size());
        $display("point_axis_rotator_test: done, errors");
        $finish;
    end

endmodule
